/* design/twf_pkg.sv */
// Shared constants and the pipeline word type for the triangle wave folder.
// No dependencies; every other design file refers to this package by scoped names.
package twf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 20;
  localparam int THR_BITS    = FRAC_BITS + 1;
  localparam int OUT_BITS    = FRAC_BITS + 2;
  // magnitude minus one fits one bit below the sample width for any nonzero sample
  localparam int DIV_BITS    = SAMPLE_BITS - 1;
  localparam int REM_BITS    = THR_BITS + 1;
  // prep stage, one stage per division step, two finishing stages
  localparam int LATENCY     = DIV_BITS + 3;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic                neg;
    logic                zero;
    logic [REM_BITS-1:0] rem;
    logic [DIV_BITS-1:0] dvd;
    logic                qbit;
  } fold_word_t;

endpackage

/* design/twf_prep.sv */
// Input stage: strip the sign and form the dividend |x| - 1.
// Depends on twf_pkg.
module twf_prep (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic signed [twf_pkg::SAMPLE_BITS-1:0]  sample,
  output logic                                    out_valid,
  output twf_pkg::fold_word_t                     out_word
);

  logic [twf_pkg::SAMPLE_BITS-1:0] mag;
  logic [twf_pkg::SAMPLE_BITS-1:0] mag_dec;
  twf_pkg::fold_word_t             word_next;

  always_comb begin
    mag     = sample[twf_pkg::SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    mag_dec = mag - 1'b1;
    word_next.neg  = sample[twf_pkg::SAMPLE_BITS-1];
    word_next.zero = (mag == '0);
    word_next.rem  = '0;
    word_next.dvd  = mag_dec[twf_pkg::DIV_BITS-1:0];
    word_next.qbit = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

/* design/twf_div_step.sv */
// One registered restoring division step of (|x| - 1) by the threshold.
// Depends on twf_pkg.
module twf_div_step (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [twf_pkg::THR_BITS-1:0]     thr,
  input  logic                             in_valid,
  input  twf_pkg::fold_word_t              in_word,
  output logic                             out_valid,
  output twf_pkg::fold_word_t              out_word
);

  logic [twf_pkg::REM_BITS-1:0] shifted;
  logic [twf_pkg::REM_BITS-1:0] thr_ext;
  logic                         fits;
  twf_pkg::fold_word_t          word_next;

  always_comb begin
    // bring down the next dividend bit
    shifted   = {in_word.rem[twf_pkg::REM_BITS-2:0], in_word.dvd[twf_pkg::DIV_BITS-1]};
    thr_ext   = twf_pkg::REM_BITS'(thr);
    fits      = (shifted >= thr_ext);
    word_next = in_word;
    word_next.rem  = fits ? (shifted - thr_ext) : shifted;
    word_next.dvd  = in_word.dvd << 1;
    word_next.qbit = fits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

/* design/twf_post.sv */
// Finishing stages: fold the remainder by quotient parity, then restore the sign.
// Depends on twf_pkg.
module twf_post (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [twf_pkg::THR_BITS-1:0]         thr,
  input  logic                                 in_valid,
  input  twf_pkg::fold_word_t                  in_word,
  output logic                                 done,
  output logic signed [twf_pkg::OUT_BITS-1:0]  sample_out
);

  logic [twf_pkg::THR_BITS-1:0] rem0;
  logic [twf_pkg::THR_BITS-1:0] mag_next;
  logic                         a_valid;
  logic                         a_neg;
  logic [twf_pkg::THR_BITS-1:0] a_mag;
  logic [twf_pkg::OUT_BITS-1:0] mag_ext;

  always_comb begin
    // remainder of (|x| - 1) / t; the true remainder is one more
    rem0 = in_word.rem[twf_pkg::THR_BITS-1:0];
    if (in_word.zero || (thr == '0)) begin
      mag_next = '0;
    end else if (in_word.qbit) begin
      mag_next = thr - rem0 - 1'b1;
    end else begin
      mag_next = rem0 + 1'b1;
    end
  end

  assign mag_ext = twf_pkg::OUT_BITS'(a_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= in_valid;
      done    <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_neg      <= in_word.neg;
    a_mag      <= mag_next;
    sample_out <= a_neg ? (~mag_ext + 1'b1) : mag_ext;
  end

endmodule

/* design/triangle_wave_folder_top.sv */
// Top level of the triangle wave folder: threshold register and pipeline chain.
// Depends on twf_pkg, twf_prep, twf_div_step and twf_post.
//
// The folder takes one signed Q3.20 sample word per clock and returns its folded
// value, Q1.20 with magnitude at most the threshold, for each word accepted (start
// high, busy low). busy stays low: a new word may enter on every clock, so the
// sustained rate is one word per cycle. The pipeline holds one
// stage for sign removal, 23 stages of a restoring divider (one quotient bit per
// stage, dividing |x| - 1 by the threshold), one stage that folds the remainder by
// quotient parity, and the output register. Each result shows on sample_out for one
// cycle with done high; the receiver must take it then. A zero sample and a zero
// threshold both give zero. The threshold resets to 1.0 and is written through
// cfg_wr_en / cfg_wr_data; write it only while no word is in flight, since the
// stages read the live register.
module triangle_wave_folder_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [twf_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                                 done,
  output logic signed [twf_pkg::OUT_BITS-1:0]  sample_out,
  input  logic                                 cfg_wr_en,
  input  logic [twf_pkg::THR_BITS-1:0]         cfg_wr_data
);

  logic [twf_pkg::THR_BITS-1:0] fold_threshold;
  logic [twf_pkg::DIV_BITS:0]   stage_valid;
  twf_pkg::fold_word_t          stage_word [twf_pkg::DIV_BITS+1];

  // the pipeline never stalls, so every start is taken
  assign busy = 1'b0;

  // hold the fold level; overwrite on a config write
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_threshold <= twf_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      fold_threshold <= cfg_wr_data;
    end
  end

  twf_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .sample    (sample_in),
    .out_valid (stage_valid[0]),
    .out_word  (stage_word[0])
  );

  // advance one quotient bit per stage
  for (genvar i = 0; i < twf_pkg::DIV_BITS; i++) begin : g_div
    twf_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .thr       (fold_threshold),
      .in_valid  (stage_valid[i]),
      .in_word   (stage_word[i]),
      .out_valid (stage_valid[i+1]),
      .out_word  (stage_word[i+1])
    );
  end

  twf_post u_post (
    .clk        (clk),
    .rst        (rst),
    .thr        (fold_threshold),
    .in_valid   (stage_valid[twf_pkg::DIV_BITS]),
    .in_word    (stage_word[twf_pkg::DIV_BITS]),
    .done       (done),
    .sample_out (sample_out)
  );

endmodule

/* design/twf_checker.sv */
// Port-level checks for the triangle wave folder, bound to the top level.
// Depends on twf_pkg and triangle_wave_folder_top.
module twf_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   start,
  input logic                                   busy,
  input logic signed [twf_pkg::SAMPLE_BITS-1:0] sample_in,
  input logic                                   done,
  input logic signed [twf_pkg::OUT_BITS-1:0]    sample_out
);

  // every accepted word yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(twf_pkg::LATENCY) done)
    else $error("accepted word produced no result");

  // no result without a word accepted one latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, twf_pkg::LATENCY))
    else $error("result without matching input");

  // a nonzero result keeps the input's sign
  a_sign_kept: assert property (@(posedge clk) disable iff (rst)
    (done && (sample_out != '0)) |->
      (sample_out[twf_pkg::OUT_BITS-1] ==
       $past(sample_in[twf_pkg::SAMPLE_BITS-1], twf_pkg::LATENCY)))
    else $error("result sign differs from input");

  // a zero sample folds to zero
  a_zero_in: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(sample_in, twf_pkg::LATENCY) == '0)) |-> (sample_out == '0))
    else $error("zero input gave nonzero result");

endmodule

bind triangle_wave_folder_top twf_checker u_twf_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .sample_in  (sample_in),
  .done       (done),
  .sample_out (sample_out)
);

/* tb/tb_top.sv */
// Self-checking bench for the triangle wave folder: a directed table, then random
// sample words over a range of fold thresholds, each result checked against a predictor.
// Depends on twf_pkg and triangle_wave_folder_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                   clk;
  logic                                   rst;
  logic                                   start;
  logic                                   busy;
  logic signed [twf_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                                   done;
  logic signed [twf_pkg::OUT_BITS-1:0]    sample_out;
  logic                                   cfg_wr_en;
  logic [twf_pkg::THR_BITS-1:0]           cfg_wr_data;

  // Typed-in expectation that travels with the word being offered.
  logic                                   fixed_ok;
  logic signed [twf_pkg::OUT_BITS-1:0]    fixed_out;

  // Threshold as the bench believes the block holds it.
  logic [twf_pkg::THR_BITS-1:0]           thr_now;
  logic signed [twf_pkg::OUT_BITS-1:0]    folded_due[$];
  int                                     mismatch_count;

  localparam int MAX_THR = (1 << twf_pkg::THR_BITS) - 1;
  localparam int MAX_MAG = 1 << (twf_pkg::SAMPLE_BITS - 1);

  triangle_wave_folder_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .sample_in  (sample_in),
    .done       (done),
    .sample_out (sample_out),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Fold one sample word: strip the sign, fold |x| between 0 and t by quotient
  // parity, then restore the sign. Zero input or zero threshold gives zero.
  function automatic logic signed [twf_pkg::OUT_BITS-1:0] folded_sample(
    input logic [twf_pkg::SAMPLE_BITS-1:0] smp,
    input logic [twf_pkg::THR_BITS-1:0]    thr
  );
    longint unsigned mag;
    longint unsigned t;
    longint unsigned quo;
    longint unsigned rem;
    longint unsigned fold;
    logic            neg;
    neg = smp[twf_pkg::SAMPLE_BITS-1];
    t   = 64'(thr);
    mag = neg ? (64'd1 << twf_pkg::SAMPLE_BITS) - 64'(smp) : 64'(smp);
    if (mag == 0 || t == 0) begin
      fold = 64'd0;
    end else begin
      quo  = (mag - 64'd1) / t;
      rem  = mag - quo * t;
      fold = quo[0] ? t - rem : rem;
    end
    return neg ? twf_pkg::OUT_BITS'(64'd0 - fold) : twf_pkg::OUT_BITS'(fold);
  endfunction

  // Draw a sample that lands on the interesting spots for threshold t: anywhere,
  // close to zero, right at a fold point, or at the range extremes.
  function automatic logic [twf_pkg::SAMPLE_BITS-1:0] pick_sample(
    input logic [twf_pkg::THR_BITS-1:0] thr
  );
    int unsigned kind;
    longint      mag;
    longint      kmax;
    logic        neg;
    kind = $urandom_range(0, 9);
    neg  = 1'($urandom_range(0, 1));
    if (kind <= 3) return twf_pkg::SAMPLE_BITS'($urandom);
    if (kind <= 5) begin
      mag = longint'($urandom_range(0, 2 * int'(thr) + 2));
    end else if (kind <= 8) begin
      kmax = (thr == 0) ? 64'sd8 : MAX_MAG / longint'(thr);
      mag  = longint'($urandom_range(0, int'(kmax))) * longint'(thr)
             + longint'($urandom_range(0, 2)) - 1;
    end else begin
      case ($urandom_range(0, 2))
        0:       mag = 0;
        1:       mag = 1;
        default: mag = MAX_MAG;
      endcase
    end
    if (mag < 0) mag = 0;
    if (mag > MAX_MAG) mag = MAX_MAG;
    if (!neg && mag == MAX_MAG) mag = MAX_MAG - 1;
    return neg ? twf_pkg::SAMPLE_BITS'(-mag) : twf_pkg::SAMPLE_BITS'(mag);
  endfunction

  // Track the threshold, queue a prediction per accepted word, check each strobe.
  always @(posedge clk) begin
    logic signed [twf_pkg::OUT_BITS-1:0] want;
    if (rst) begin
      thr_now = twf_pkg::THR_RESET;
    end else begin
      if (done) begin
        if (folded_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result %0d, nothing pending", $realtime, sample_out);
        end else begin
          want = folded_due.pop_front();
          if (sample_out !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: sample_out mismatch: expected %0d, got %0d",
                       $realtime, want, sample_out);
          end
        end
      end
      if (start && !busy)
        folded_due.push_back(fixed_ok ? fixed_out : folded_sample(sample_in, thr_now));
      if (cfg_wr_en)
        thr_now = cfg_wr_data;
    end
  end

  // Offer one word, idling first with the given odds; leave start high on return
  // so back-to-back words keep it up without a dip.
  task automatic push_word(input logic [twf_pkg::SAMPLE_BITS-1:0] smp, input int idle_pct,
                           input logic chk, input int want);
    while ($urandom_range(0, 99) < idle_pct) begin
      start     <= 1'b0;
      sample_in <= twf_pkg::SAMPLE_BITS'($urandom);
      @(negedge clk);
    end
    start     <= 1'b1;
    sample_in <= smp;
    fixed_ok  <= chk;
    fixed_out <= twf_pkg::OUT_BITS'(want);
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start and hold until every pending word has come back.
  task automatic wait_drained();
    start    <= 1'b0;
    fixed_ok <= 1'b0;
    while (folded_due.size() != 0) @(negedge clk);
  endtask

  // Write the fold threshold; only ever called with the pipeline empty.
  task automatic set_threshold(input int thr);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= twf_pkg::THR_BITS'(thr);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  typedef struct {
    int thr;
    int smp;
    bit chk;
    int want;
  } probe_row_t;

  initial begin : stimulus
    probe_row_t                   probes[22];
    int                           thr_set;
    int                           phase_thr[9];
    int                           idle_mode[3];
    int                           pct;
    logic [twf_pkg::THR_BITS-1:0] t;

    rst            = 1'b1;
    start          = 1'b0;
    sample_in      = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    fixed_ok       = 1'b0;
    fixed_out      = '0;
    mismatch_count = 0;

    // Threshold, sample, whether the result is typed in, and that result.
    probes = '{
      '{1048576,        0, 1,        0},  // zero input after reset
      '{1048576,        1, 1,        1},
      '{1048576,       -1, 1,       -1},
      '{1048576,  1048576, 1,  1048576},  // exactly at the threshold
      '{1048576, -1048576, 1, -1048576},
      '{1048576,  1048577, 1,  1048575},  // just past the first fold
      '{1048576,  2097152, 1,        0},  // folded all the way back to zero
      '{1048576,  8388607, 1,        1},  // largest positive sample
      '{1048576, -8388608, 1,        0},  // most negative sample
      '{1048576,  3145727, 0,        0},
      '{      0,  8388607, 1,        0},  // zero threshold
      '{      0, -8388608, 1,        0},
      '{      0,    12345, 1,        0},
      '{MAX_THR,  2097151, 1,  2097151},  // threshold above 1.0
      '{MAX_THR, -2097151, 1, -2097151},
      '{MAX_THR,  8388607, 0,        0},
      '{MAX_THR, -8388608, 0,        0},
      '{MAX_THR,  2097152, 0,        0},
      '{      1,        7, 0,        0},  // smallest nonzero threshold
      '{      1,        8, 0,        0},
      '{      1, -8388608, 0,        0},
      '{1048576,   524288, 0,        0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: change the threshold only between drained groups.
    thr_set = int'(twf_pkg::THR_RESET);
    foreach (probes[i]) begin
      if (probes[i].thr != thr_set) begin
        set_threshold(probes[i].thr);
        thr_set = probes[i].thr;
      end
      push_word(twf_pkg::SAMPLE_BITS'(probes[i].smp), 0, probes[i].chk, probes[i].want);
    end

    // Random part: one threshold per phase, extremes included, idling rotating
    // through none, heavy and light sender gaps.
    phase_thr = '{int'(twf_pkg::THR_RESET), 0, MAX_THR, 1, int'($urandom_range(0, MAX_THR)),
                  int'($urandom_range(2, 64)), int'($urandom_range(4096, 1048576)), 3,
                  int'($urandom_range(1048577, MAX_THR))};
    idle_mode = '{0, 72, 28};
    foreach (phase_thr[ph]) begin
      set_threshold(phase_thr[ph]);
      t   = twf_pkg::THR_BITS'(phase_thr[ph]);
      pct = idle_mode[ph % 3];
      repeat (210) begin
        // flip between bursts and gaps now and then inside a phase
        if ($urandom_range(0, 49) == 0) pct = idle_mode[$urandom_range(0, 2)];
        push_word(pick_sample(t), pct, 1'b0, 0);
      end
    end

    wait_drained();
    // give a stray strobe time to show
    repeat (twf_pkg::LATENCY + 8) @(negedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
